[sv/ic_pkg.sv]
package ic_pkg;

    localparam int MAX_LEN    = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IN_WIDTH   = 32;
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int OCC_W      = $clog2(MAX_LEN + 1);
    localparam int TOT_W      = 11;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ic_cmd_t;

    typedef struct packed {
        logic scan_done;
    } ic_status_t;

endpackage

[sv/inversion_counter.sv]
// inversion_counter: running inversion count over a sequence of signed words
//
// input channel (in_valid / in_stall): one word per beat in value, last marks
// the final word of a sequence. output channel (out_valid / out_stall): one
// result beat per input beat, in order, carrying the running count of pairs
// i<j with A[j] < A[i], a copy of last in is_final and a sticky overflow flag.
// words past the 64th of a sequence are dropped and set overflow.
//
// each word is compared against the stored words of its sequence one at a
// time through the single read port of the word store, so a new word is not
// taken until the scan and the update of the last one are through. the result
// appears in the same cycle that the next word can be taken.
//
// the result sits in an output register: a new word is accepted and scanned
// while an earlier result waits under out_stall; only the final update waits
// for the register to free up. reset clears the count, the fill level and the
// flag; the store needs no clearing pass, only filled entries are ever read.
module inversion_counter
    import ic_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [IN_WIDTH-1:0] value,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TOT_W-1:0]    inversions,
    output logic                is_final,
    output logic                overflow
);

    ic_cmd_t    cmd;
    ic_status_t status;

    ic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    ic_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .last       (last),
        .cmd        (cmd),
        .status     (status),
        .inversions (inversions),
        .is_final   (is_final),
        .overflow   (overflow)
    );

endmodule

[sv/ic_ram.sv]
module ic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/ic_datapath.sv]
module ic_datapath
    import ic_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IN_WIDTH-1:0] value,
    input  logic                last,
    input  ic_cmd_t             cmd,
    output ic_status_t          status,
    output logic [TOT_W-1:0]    inversions,
    output logic                is_final,
    output logic                overflow
);

    logic [DATA_WIDTH-1:0] key_reg;
    logic                  last_reg;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic                  ovf_reg, ovf_next;
    logic [OCC_W-1:0]      idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [OCC_W-1:0]      greater_reg, greater_next;
    logic [TOT_W-1:0]      inv_out_reg;
    logic                  final_out_reg;
    logic                  ovf_out_reg;

    logic                  full;
    logic                  issue;
    logic [DATA_WIDTH-1:0] rdata;
    logic [TOT_W:0]        sum;
    logic [TOT_W-1:0]      total_sat;
    logic [DATA_WIDTH-1:0] key_in;

    // offset binary so that unsigned order matches signed order
    assign key_in = value[DATA_WIDTH-1:0] ^ {1'b1, {(DATA_WIDTH-1){1'b0}}};

    assign full  = (occ_reg == OCC_W'(MAX_LEN));
    assign issue = cmd.scan && !full && (idx_reg < occ_reg);
    assign sum   = {1'b0, total_reg} + (TOT_W+1)'(greater_reg);
    assign total_sat = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];

    assign status.scan_done = full || ((idx_reg == occ_reg) && !pend_reg);

    ic_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (cmd.commit && !full),
        .waddr (occ_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        greater_next = greater_reg;
        occ_next     = occ_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        if (cmd.load)
        begin
            idx_next     = '0;
            pend_next    = 1'b0;
            greater_next = '0;
        end
        else if (cmd.scan)
        begin
            pend_next = issue;
            if (issue)
            begin
                idx_next = idx_reg + OCC_W'(1);
            end
            // read data comes from a registered read, in the cycle after its address
            if (pend_reg && (rdata > key_reg))
            begin
                greater_next = greater_reg + OCC_W'(1);
            end
        end
        if (cmd.commit)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                total_next = total_sat;
                occ_next   = occ_reg + OCC_W'(1);
            end
            if (last_reg)
            begin
                occ_next   = '0;
                total_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            greater_reg <= '0;
        end
        else
        begin
            occ_reg     <= occ_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            greater_reg <= greater_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key_in;
            last_reg <= last;
        end
        if (cmd.commit)
        begin
            inv_out_reg   <= full ? total_reg : total_sat;
            final_out_reg <= last_reg;
            ovf_out_reg   <= full | ovf_reg;
        end
    end

    assign inversions = inv_out_reg;
    assign is_final   = final_out_reg;
    assign overflow   = ovf_out_reg;

endmodule

[sv/ic_ctrl.sv]
module ic_ctrl
    import ic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output ic_cmd_t    cmd,
    input  ic_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the finished count until the output register frees up
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/ic_checker.sv]
module ic_checker
    import ic_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [IN_WIDTH-1:0] value,
    input logic                last,
    input logic                out_valid,
    input logic                out_stall,
    input logic [TOT_W-1:0]    inversions,
    input logic                is_final,
    input logic                overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(inversions) && $stable(is_final)
            && $stable(overflow))
        else $error("result payload changed under stall");

    // the source holds a stalled word steady
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(value) && $stable(last))
        else $error("input beat changed under stall");

    // a word is always scanned before the next one is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while first still in flight");

    // a result needs a scan and an update after acceptance
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared before its word was scanned");

endmodule

bind inversion_counter ic_checker u_ic_checker (.*);

[sim/inversion_checker.sv]
`timescale 1ns / 1ps

module inversion_checker
    import ic_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [IN_WIDTH-1:0] value,
    input  logic                last,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [TOT_W-1:0]    inversions,
    input  logic                is_final,
    input  logic                overflow,
    output int                  mismatches,
    output int                  outstanding
);

    localparam int TOTAL_CAP = (1 << TOT_W) - 1;

    typedef struct packed {
        logic [TOT_W-1:0] inversions;
        logic             is_final;
        logic             overflow;
    } inv_result_t;

    // words of the open sequence, in arrival order
    logic signed [DATA_WIDTH-1:0] seq_words [MAX_LEN];
    int                           seq_fill;
    int                           seq_count;
    logic                         seq_overflow;
    inv_result_t                  pending_counts [$];
    int                           error_count;
    int                           result_index;

    function automatic int count_greater(input logic signed [DATA_WIDTH-1:0] word);
        int n;
        n = 0;
        for (int i = 0; i < seq_fill; i++)
        begin
            if (seq_words[i] > word)
                n++;
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        inv_result_t want;
        inv_result_t got;
        if (!rst_n)
        begin
            seq_fill     = 0;
            seq_count    = 0;
            seq_overflow = 1'b0;
            error_count  = 0;
            result_index = 0;
            pending_counts.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (seq_fill < MAX_LEN)
                begin
                    seq_count += count_greater(value[DATA_WIDTH-1:0]);
                    if (seq_count > TOTAL_CAP)
                        seq_count = TOTAL_CAP;
                    seq_words[seq_fill] = value[DATA_WIDTH-1:0];
                    seq_fill++;
                end
                else
                begin
                    // store full: word dropped, total unchanged
                    seq_overflow = 1'b1;
                end
                want.inversions = seq_count[TOT_W-1:0];
                want.is_final   = last;
                want.overflow   = seq_overflow;
                pending_counts.push_back(want);
                if (last)
                begin
                    seq_fill     = 0;
                    seq_count    = 0;
                    seq_overflow = 1'b0;
                end
            end

            if (out_valid && !out_stall)
            begin
                got.inversions = inversions;
                got.is_final   = is_final;
                got.overflow   = overflow;
                if (pending_counts.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result beat %0d: none expected, got inversions=%0d is_final=%0b overflow=%0b",
                                 result_index, got.inversions, got.is_final, got.overflow);
                end
                else
                begin
                    want = pending_counts.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("result beat %0d: expected inversions=%0d is_final=%0b overflow=%0b, got inversions=%0d is_final=%0b overflow=%0b",
                                     result_index, want.inversions, want.is_final, want.overflow,
                                     got.inversions, got.is_final, got.overflow);
                    end
                end
                result_index++;
            end

            mismatches  <= error_count;
            outstanding <= pending_counts.size();
        end
    end

endmodule

[sim/tb_inversion_counter.sv]
`timescale 1ns / 1ps

module tb_inversion_counter;
    import ic_pkg::*;

    localparam int RANDOM_WORDS = 630;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;

    typedef enum int {
        FILL_WIDE,
        FILL_NARROW,
        FILL_FALLING,
        FILL_RISING,
        FILL_EXTREME
    } fill_mode_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [IN_WIDTH-1:0] value;
    logic                last;
    logic                out_valid;
    logic                out_stall;
    logic [TOT_W-1:0]    inversions;
    logic                is_final;
    logic                overflow;

    int mismatches;
    int outstanding;
    int words_sent;
    int idle_cycles;

    inversion_counter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inversions (inversions),
        .is_final   (is_final),
        .overflow   (overflow)
    );

    inversion_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .inversions  (inversions),
        .is_final    (is_final),
        .overflow    (overflow),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic [IN_WIDTH-1:0] word, input logic closes, input int gap);
        in_valid <= 1'b1;
        value    <= word;
        last     <= closes;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            value    <= $urandom;
            last     <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_sequence(input int len, input fill_mode_t mode, input logic eager);
        logic [IN_WIDTH-1:0] word;
        word = $urandom;
        // keep falling runs clear of the signed wrap point
        if (mode == FILL_FALLING)
            word[IN_WIDTH-1:IN_WIDTH-2] = 2'b01;
        for (int k = 0; k < len; k++)
        begin
            case (mode)
                FILL_WIDE:    word = $urandom;
                FILL_NARROW:  word = IN_WIDTH'($urandom_range(0, 8)) - IN_WIDTH'(4);
                FILL_FALLING: word = word - IN_WIDTH'($urandom_range(1, 3));
                FILL_RISING:  word = word + IN_WIDTH'($urandom_range(0, 3));
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       word = 32'h8000_0000;
                        1:       word = 32'h7fff_ffff;
                        2:       word = '0;
                        default: word = '1;
                    endcase
                end
            endcase
            send_word(word, k == len - 1, eager ? 0 : pick_gap());
        end
    endtask

    // sink side: free runs of varied length, mostly short stalls, now and then long ones
    initial
    begin
        int run;
        int hold;
        out_stall <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            out_stall <= 1'b1;
            repeat (hold) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int len;
        int r;
        fill_mode_t mode;
        words_sent  = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= '0;
        last     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-word sequence at the most negative value
        send_word(32'h8000_0000, 1'b1, pick_gap());
        // extremes in falling signed order
        send_word(32'h7fff_ffff, 1'b0, pick_gap());
        send_word(32'h0000_0000, 1'b0, pick_gap());
        send_word(32'hffff_ffff, 1'b0, pick_gap());
        send_word(32'h8000_0000, 1'b0, pick_gap());
        send_word(32'h0000_0001, 1'b1, pick_gap());
        // equal words add nothing
        send_word(32'h0000_0005, 1'b0, pick_gap());
        send_word(32'h0000_0005, 1'b0, pick_gap());
        send_word(32'h0000_0005, 1'b0, pick_gap());
        send_word(32'hffff_fffd, 1'b0, pick_gap());
        send_word(32'hffff_fffd, 1'b1, pick_gap());
        // rising order, no inversions
        send_word(32'h8000_0000, 1'b0, pick_gap());
        send_word(32'hffff_ffff, 1'b0, pick_gap());
        send_word(32'h0000_0000, 1'b0, pick_gap());
        send_word(32'h7fff_ffff, 1'b1, pick_gap());
        send_word(32'haaaa_aaaa, 1'b0, pick_gap());
        send_word(32'h5555_5555, 1'b1, pick_gap());

        // full store in strict falling order, then dropped words with last on a dropped one
        send_sequence(MAX_LEN + 2, FILL_FALLING, 1'b0);

        while (words_sent < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                len = $urandom_range(1, 8);
            else if (r < 88)
                len = $urandom_range(9, MAX_LEN - 1);
            else
                len = $urandom_range(MAX_LEN, MAX_LEN + 8);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mode = FILL_WIDE;
                4, 5:       mode = FILL_NARROW;
                6:          mode = FILL_FALLING;
                7:          mode = FILL_RISING;
                default:    mode = FILL_EXTREME;
            endcase
            send_sequence(len, mode, $urandom_range(0, 4) == 0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
